[sv/qrs_pkg.sv]
// Shared types, constants and codes of the QRS peak detector.
// Used by the channel interfaces, the controller, the datapath and the divider.
`timescale 1ns / 1ps
`default_nettype none

package qrs_pkg;

  localparam int SAMPLE_W   = 18;
  localparam int TIME_W     = 24;
  localparam int RATE_W     = 14;
  localparam int MISS_W     = 3;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;
  localparam int DIV_NW     = 32;
  localparam int DIV_DW     = 24;

  localparam int PEAK_DEPTH_DEF = 64;
  localparam int RR_WINDOW_DEF  = 8;

  localparam logic [SAMPLE_W-1:0] WEAK_LEVEL_RST   = 18'd2000;
  localparam logic [MISS_W-1:0]   MISS_LIMIT_RST   = 3'd5;
  localparam logic [SAMPLE_W-1:0] START_SIGNAL_RST = '0;
  localparam logic [SAMPLE_W-1:0] START_NOISE_RST  = '0;
  localparam logic [TIME_W-1:0]   START_RR_LOW_RST = '0;
  localparam logic [TIME_W-1:0]   START_RR_HIGH_RST = '1;
  localparam logic [TIME_W-1:0]   START_RR_MISS_RST = '1;

  localparam logic [DIV_NW-1:0] PCT_LOW  = 32'd92;
  localparam logic [DIV_NW-1:0] PCT_HIGH = 32'd116;
  localparam logic [DIV_NW-1:0] PCT_MISS = 32'd166;
  // ceil(2^38 / 100): exact floor division by 100 for any 32-bit product
  localparam logic [DIV_NW-1:0] PCT_RECIP = 32'd2748779070;
  localparam int                PCT_SHIFT = 38;
  localparam logic [DIV_NW-1:0] RATE_NUM = 32'd15000;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WEAK_LEVEL,
    CFG_MISS_LIMIT,
    CFG_START_SIGNAL,
    CFG_START_NOISE,
    CFG_START_RR_LOW,
    CFG_START_RR_HIGH,
    CFG_START_RR_MISS
  } cfg_idx_t;

  typedef enum logic [4:0] {
    CMD_NONE,
    CMD_LOAD,
    CMD_RESTART,
    CMD_STORE,
    CMD_NOISE,
    CMD_THR,
    CMD_BEAT,
    CMD_MISS,
    CMD_SB_START,
    CMD_SB_READ,
    CMD_SB_NEXT,
    CMD_SB_HIT,
    CMD_SUM_ALL,
    CMD_SUM_GOOD,
    CMD_DIV_AVG_ALL,
    CMD_DIV_AVG_GOOD,
    CMD_DIV_LOW,
    CMD_DIV_HIGH,
    CMD_DIV_MISS,
    CMD_DIV_RATE,
    CMD_PUT_AVG_ALL,
    CMD_PUT_AVG_GOOD,
    CMD_PUT_LOW,
    CMD_PUT_HIGH,
    CMD_PUT_MISS,
    CMD_PUT_RATE,
    CMD_EMIT
  } cmd_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_DECODE,
    S_STORE,
    S_CLASSIFY,
    S_THR,
    S_SB_START,
    S_SB_READ,
    S_SB_CHECK,
    S_SUM_ALL,
    S_AVG_ALL_GO,
    S_AVG_ALL_WAIT,
    S_SUM_GOOD,
    S_AVG_GOOD_GO,
    S_AVG_GOOD_WAIT,
    S_LOW_GO,
    S_LOW_WAIT,
    S_HIGH_GO,
    S_HIGH_WAIT,
    S_MISS_GO,
    S_MISS_WAIT,
    S_RATE_GO,
    S_RATE_WAIT,
    S_EMIT
  } state_t;

  typedef struct packed {
    logic                op;
    logic [SAMPLE_W-1:0] s1;
    logic [SAMPLE_W-1:0] s2;
    logic [SAMPLE_W-1:0] s3;
    logic [SAMPLE_W-1:0] s4;
    logic [SAMPLE_W-1:0] s5;
    logic [TIME_W-1:0]   stamp;
  } in_t;

  typedef struct packed {
    logic                beat;
    logic                by_searchback;
    logic [SAMPLE_W-1:0] beat_value;
    logic [TIME_W-1:0]   beat_time;
    logic [TIME_W-1:0]   rr_interval;
    logic [RATE_W-1:0]   pulse_rate;
    logic                weak_beat;
    logic                unstable;
  } res_t;

  typedef struct packed {
    logic op;
    logic is_peak;
    logic above;
    logic in_win;
    logic over_miss;
    logic sb_end;
    logic sb_hit;
    logic all_last;
    logic good_last;
    logic div_done;
    logic sb;
  } st_t;

endpackage

`default_nettype wire

[sv/qrs_ifs.sv]
// Valid/ready channel interfaces for the sample window items and the beat results.
// Depends on qrs_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none

interface qrs_in_if;
  logic                          valid;
  logic                          ready;
  logic                          op;
  logic [qrs_pkg::SAMPLE_W-1:0]  s1;
  logic [qrs_pkg::SAMPLE_W-1:0]  s2;
  logic [qrs_pkg::SAMPLE_W-1:0]  s3;
  logic [qrs_pkg::SAMPLE_W-1:0]  s4;
  logic [qrs_pkg::SAMPLE_W-1:0]  s5;
  logic [qrs_pkg::TIME_W-1:0]    stamp;

  modport source (output valid, op, s1, s2, s3, s4, s5, stamp, input ready);
  modport sink   (input valid, op, s1, s2, s3, s4, s5, stamp, output ready);
endinterface

interface qrs_out_if;
  logic                          valid;
  logic                          ready;
  logic                          beat;
  logic                          by_searchback;
  logic [qrs_pkg::SAMPLE_W-1:0]  beat_value;
  logic [qrs_pkg::TIME_W-1:0]    beat_time;
  logic [qrs_pkg::TIME_W-1:0]    rr_interval;
  logic [qrs_pkg::RATE_W-1:0]    pulse_rate;
  logic                          weak_beat;
  logic                          unstable;

  modport source (output valid, beat, by_searchback, beat_value, beat_time, rr_interval,
                  pulse_rate, weak_beat, unstable, input ready);
  modport sink   (input valid, beat, by_searchback, beat_value, beat_time, rr_interval,
                  pulse_rate, weak_beat, unstable, output ready);
endinterface

`default_nettype wire

[sv/qrs_peak_detector.sv]
// QRS peak detector top level: one item in process at a time; the next can be taken in the
// cycle after the result enters the output register, which waits while the sink holds off the
// last result. A restart or a non-peak window goes straight to the result; a peak is stored and
// classified as noise, a plain miss or a beat. A beat sums each RR ring and runs the divisions;
// a searchback examines stored peaks in turn, and a hit also sums the all-RR ring. Synchronous
// active-low reset loads state and configuration; the peak ring and RR rings are not cleared.
`timescale 1ns / 1ps
`default_nettype none

module qrs_peak_detector #(
  parameter int PEAK_DEPTH = qrs_pkg::PEAK_DEPTH_DEF,
  parameter int RR_WINDOW  = qrs_pkg::RR_WINDOW_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  qrs_in_if.sink                          in_ch,
  qrs_out_if.source                       out_ch,
  input  logic                            cfg_we,
  input  logic [qrs_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [qrs_pkg::CFG_DATA_W-1:0]  cfg_data
);

  qrs_pkg::in_t  in_item;
  qrs_pkg::res_t out_res;
  qrs_pkg::st_t  st;
  qrs_pkg::cmd_t cmd;

  always_comb begin
    in_item.op    = in_ch.op;
    in_item.s1    = in_ch.s1;
    in_item.s2    = in_ch.s2;
    in_item.s3    = in_ch.s3;
    in_item.s4    = in_ch.s4;
    in_item.s5    = in_ch.s5;
    in_item.stamp = in_ch.stamp;
  end

  qrs_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .st        (st),
    .cmd       (cmd)
  );

  qrs_dp #(
    .PEAK_DEPTH (PEAK_DEPTH),
    .RR_WINDOW  (RR_WINDOW)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_item   (in_item),
    .cmd       (cmd),
    .st        (st),
    .out_res   (out_res)
  );

  assign out_ch.beat          = out_res.beat;
  assign out_ch.by_searchback = out_res.by_searchback;
  assign out_ch.beat_value    = out_res.beat_value;
  assign out_ch.beat_time     = out_res.beat_time;
  assign out_ch.rr_interval   = out_res.rr_interval;
  assign out_ch.pulse_rate    = out_res.pulse_rate;
  assign out_ch.weak_beat     = out_res.weak_beat;
  assign out_ch.unstable      = out_res.unstable;

endmodule

`default_nettype wire

[sv/qrs_div.sv]
// Radix-2 restoring divider, one quotient bit per cycle.
// Depends on qrs_pkg for operand widths.
`timescale 1ns / 1ps
`default_nettype none

module qrs_div (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [qrs_pkg::DIV_NW-1:0]  dividend,
  input  logic [qrs_pkg::DIV_DW-1:0]  divisor,
  output logic [qrs_pkg::DIV_NW-1:0]  quotient,
  output logic                        done
);

  localparam int NW = qrs_pkg::DIV_NW;
  localparam int DW = qrs_pkg::DIV_DW;
  localparam int CNTW = $clog2(NW + 1);
  localparam logic [CNTW-1:0] STEPS = CNTW'(NW);

  logic [NW-1:0]   q_r;
  logic [DW-1:0]   rem_r;
  logic [DW-1:0]   den_r;
  logic [CNTW-1:0] cnt_r;
  logic            busy_r;
  logic            done_r;

  logic [DW:0]     shifted;
  logic            ge;
  logic [DW-1:0]   rem_nxt;

  assign shifted = {rem_r, q_r[NW-1]};
  assign ge      = shifted >= {1'b0, den_r};
  assign rem_nxt = ge ? DW'(shifted - {1'b0, den_r}) : shifted[DW-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= STEPS;
      end else if (busy_r) begin
        cnt_r <= cnt_r - CNTW'(1);
        if (cnt_r == CNTW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      q_r   <= dividend;
      rem_r <= '0;
      den_r <= divisor;
    end else if (busy_r) begin
      q_r   <= {q_r[NW-2:0], ge};
      rem_r <= rem_nxt;
    end
  end

  assign quotient = q_r;
  assign done     = done_r;

endmodule

`default_nettype wire

[sv/qrs_dp.sv]
// Datapath of the QRS peak detector: configuration, detector state, peak ring,
// RR rings, shared divider and the output register. Depends on qrs_pkg, qrs_div.
`timescale 1ns / 1ps
`default_nettype none

module qrs_dp #(
  parameter int PEAK_DEPTH = qrs_pkg::PEAK_DEPTH_DEF,
  parameter int RR_WINDOW  = qrs_pkg::RR_WINDOW_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [qrs_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [qrs_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  qrs_pkg::in_t                    in_item,
  input  qrs_pkg::cmd_t                   cmd,
  output qrs_pkg::st_t                    st,
  output qrs_pkg::res_t                   out_res
);

  localparam int SAW  = qrs_pkg::SAMPLE_W;
  localparam int TW   = qrs_pkg::TIME_W;
  localparam int NW   = qrs_pkg::DIV_NW;
  localparam int DW   = qrs_pkg::DIV_DW;
  localparam int PW   = 2 * NW;
  localparam int PQW  = PW - qrs_pkg::PCT_SHIFT;
  localparam int SW   = $clog2(PEAK_DEPTH);
  localparam int IW   = $clog2(RR_WINDOW);
  localparam int CW   = $clog2(RR_WINDOW + 1);
  localparam int SUMW = TW + IW;
  localparam logic [SW-1:0] SLOT_LAST = SW'(PEAK_DEPTH - 1);
  localparam logic [IW-1:0] POS_LAST  = IW'(RR_WINDOW - 1);
  localparam logic [CW-1:0] CNT_FULL  = CW'(RR_WINDOW);
  localparam logic [TW-1:0] TIME_MAX  = '1;

  // configuration
  logic [SAW-1:0]            weak_level_r;
  logic [qrs_pkg::MISS_W-1:0] miss_limit_r;
  logic [SAW-1:0]            start_signal_r;
  logic [SAW-1:0]            start_noise_r;
  logic [TW-1:0]             start_rr_low_r;
  logic [TW-1:0]             start_rr_high_r;
  logic [TW-1:0]             start_rr_miss_r;

  // detector state
  logic [TW-1:0]             peak_count_r;
  logic [SW-1:0]             slot_r;
  logic [SAW-1:0]            signal_r;
  logic [SAW-1:0]            noise_r;
  logic [SAW-1:0]            upper_r;
  logic [SAW-1:0]            lower_r;
  logic [TW-1:0]             rr_low_r;
  logic [TW-1:0]             rr_high_r;
  logic [TW-1:0]             rr_miss_r;
  logic [TW-1:0]             last_time_r;
  logic [qrs_pkg::MISS_W-1:0] misses_r;
  logic [CW-1:0]             all_cnt_r;
  logic [CW-1:0]             good_cnt_r;
  logic [IW-1:0]             all_pos_r;
  logic [IW-1:0]             good_pos_r;
  logic [TW-1:0]             avg_all_r;
  logic [TW-1:0]             avg_good_r;
  logic                      sb_r;

  // working registers
  qrs_pkg::in_t              item_r;
  qrs_pkg::res_t             res_r;
  qrs_pkg::res_t             out_r;
  logic [TW-1:0]             rr_r;
  logic [SUMW-1:0]           acc_r;
  logic [IW-1:0]             idx_r;
  logic [SW-1:0]             cur_r;
  logic [SW-1:0]             n_r;
  logic [SW-1:0]             avail_r;
  logic [SAW-1:0]            rd_val_r;
  logic [TW-1:0]             rd_time_r;
  logic [NW-1:0]             pct_prod_r;
  logic                      pct_go_r;
  logic                      pct_done_r;
  logic [TW-1:0]             pct_q_r;

  logic [TW-1:0]             all_ring  [RR_WINDOW];
  logic [TW-1:0]             good_ring [RR_WINDOW];
  logic [SAW-1:0]            peak_val_mem  [PEAK_DEPTH];
  logic [TW-1:0]             peak_time_mem [PEAK_DEPTH];

  // combinational helpers
  logic [19:0]               thr_sum;
  logic [SAW-1:0]            upper_new;
  logic [20:0]               noise_sum;
  logic [20:0]               sigb_sum;
  logic [19:0]               sigs_sum;
  logic [TW-1:0]             rr_new;
  logic [TW-1:0]             srr;
  logic [TW-1:0]             cm1;
  logic [SW-1:0]             avail_new;
  logic [SW-1:0]             cur_dec;
  logic [qrs_pkg::MISS_W-1:0] misses_inc;
  logic                      miss_hit;
  logic [TW-1:0]             avg_sel;
  logic                      div_start;
  logic [NW-1:0]             dvd;
  logic [DW-1:0]             dvs;
  logic [NW-1:0]             quot;
  logic                      div_done;
  logic                      pct_start;
  logic [NW-1:0]             pct_dvd;
  logic [PW-1:0]             pct_full;
  logic [PQW-1:0]            pct_quot;
  logic [TW-1:0]             pct_sat;
  logic [CW-1:0]             all_cnt_inc;
  logic [CW-1:0]             good_cnt_inc;
  logic [IW-1:0]             all_pos_inc;
  logic [IW-1:0]             good_pos_inc;

  assign thr_sum   = 20'(noise_r) * 20'd3 + 20'(signal_r);
  assign upper_new = thr_sum[19:2];
  assign noise_sum = 21'(noise_r) * 21'd7 + 21'(item_r.s3);
  assign sigb_sum  = 21'(signal_r) * 21'd7 + 21'(item_r.s3);
  assign sigs_sum  = 20'(signal_r) * 20'd3 + 20'(rd_val_r);
  assign rr_new    = item_r.stamp - last_time_r;
  assign srr       = rd_time_r - last_time_r;
  assign cm1       = peak_count_r - TW'(1);
  assign avail_new = (cm1 > TW'(PEAK_DEPTH - 1)) ? SLOT_LAST : cm1[SW-1:0];
  assign cur_dec   = (cur_r == '0) ? SLOT_LAST : cur_r - SW'(1);
  assign misses_inc = misses_r + 3'd1;
  assign miss_hit  = misses_inc >= miss_limit_r;
  assign avg_sel   = sb_r ? avg_all_r : avg_good_r;

  // divide by 100: multiply by the reciprocal, drop the fraction, saturate
  assign pct_full = PW'(pct_prod_r) * PW'(qrs_pkg::PCT_RECIP);
  assign pct_quot = pct_full[PW-1:qrs_pkg::PCT_SHIFT];
  assign pct_sat  = (pct_quot[PQW-1:TW] != '0) ? TIME_MAX : pct_quot[TW-1:0];

  assign all_cnt_inc  = (all_cnt_r == CNT_FULL) ? all_cnt_r : all_cnt_r + CW'(1);
  assign good_cnt_inc = (good_cnt_r == CNT_FULL) ? good_cnt_r : good_cnt_r + CW'(1);
  assign all_pos_inc  = (all_pos_r == POS_LAST) ? '0 : all_pos_r + IW'(1);
  assign good_pos_inc = (good_pos_r == POS_LAST) ? '0 : good_pos_r + IW'(1);

  // divider and scaler operand selection
  always_comb begin
    div_start = 1'b0;
    dvd       = '0;
    dvs       = '0;
    pct_start = 1'b0;
    pct_dvd   = '0;
    unique case (cmd)
      qrs_pkg::CMD_DIV_AVG_ALL: begin
        div_start = 1'b1;
        dvd       = NW'(acc_r);
        dvs       = DW'(all_cnt_r);
      end
      qrs_pkg::CMD_DIV_AVG_GOOD: begin
        div_start = 1'b1;
        dvd       = NW'(acc_r);
        dvs       = DW'(good_cnt_r);
      end
      qrs_pkg::CMD_DIV_LOW: begin
        pct_start = 1'b1;
        pct_dvd   = NW'(avg_sel) * qrs_pkg::PCT_LOW;
      end
      qrs_pkg::CMD_DIV_HIGH: begin
        pct_start = 1'b1;
        pct_dvd   = NW'(avg_sel) * qrs_pkg::PCT_HIGH;
      end
      qrs_pkg::CMD_DIV_MISS: begin
        pct_start = 1'b1;
        pct_dvd   = NW'(avg_sel) * qrs_pkg::PCT_MISS;
      end
      qrs_pkg::CMD_DIV_RATE: begin
        div_start = 1'b1;
        dvd       = qrs_pkg::RATE_NUM;
        dvs       = DW'(rr_r);
      end
      default: ;
    endcase
  end

  qrs_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (dvd),
    .divisor  (dvs),
    .quotient (quot),
    .done     (div_done)
  );

  // percentage scaler: the product is registered first, then the quotient
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pct_go_r   <= 1'b0;
      pct_done_r <= 1'b0;
    end else begin
      pct_go_r   <= pct_start;
      pct_done_r <= pct_go_r;
    end
  end

  always_ff @(posedge clk) begin
    if (pct_start) pct_prod_r <= pct_dvd;
    if (pct_go_r)  pct_q_r    <= pct_sat;
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      weak_level_r    <= qrs_pkg::WEAK_LEVEL_RST;
      miss_limit_r    <= qrs_pkg::MISS_LIMIT_RST;
      start_signal_r  <= qrs_pkg::START_SIGNAL_RST;
      start_noise_r   <= qrs_pkg::START_NOISE_RST;
      start_rr_low_r  <= qrs_pkg::START_RR_LOW_RST;
      start_rr_high_r <= qrs_pkg::START_RR_HIGH_RST;
      start_rr_miss_r <= qrs_pkg::START_RR_MISS_RST;
    end else if (cfg_we) begin
      unique case (qrs_pkg::cfg_idx_t'(cfg_index))
        qrs_pkg::CFG_WEAK_LEVEL:    weak_level_r    <= cfg_data[SAW-1:0];
        qrs_pkg::CFG_MISS_LIMIT:    miss_limit_r    <= cfg_data[qrs_pkg::MISS_W-1:0];
        qrs_pkg::CFG_START_SIGNAL:  start_signal_r  <= cfg_data[SAW-1:0];
        qrs_pkg::CFG_START_NOISE:   start_noise_r   <= cfg_data[SAW-1:0];
        qrs_pkg::CFG_START_RR_LOW:  start_rr_low_r  <= cfg_data[TW-1:0];
        qrs_pkg::CFG_START_RR_HIGH: start_rr_high_r <= cfg_data[TW-1:0];
        qrs_pkg::CFG_START_RR_MISS: start_rr_miss_r <= cfg_data[TW-1:0];
        default: ;
      endcase
    end
  end

  // detector state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      peak_count_r <= '0;
      slot_r       <= '0;
      signal_r     <= qrs_pkg::START_SIGNAL_RST;
      noise_r      <= qrs_pkg::START_NOISE_RST;
      upper_r      <= '0;
      lower_r      <= '0;
      rr_low_r     <= qrs_pkg::START_RR_LOW_RST;
      rr_high_r    <= qrs_pkg::START_RR_HIGH_RST;
      rr_miss_r    <= qrs_pkg::START_RR_MISS_RST;
      last_time_r  <= '0;
      misses_r     <= '0;
      all_cnt_r    <= '0;
      good_cnt_r   <= '0;
      all_pos_r    <= '0;
      good_pos_r   <= '0;
      avg_all_r    <= '0;
      avg_good_r   <= '0;
      sb_r         <= 1'b0;
    end else begin
      unique case (cmd)
        qrs_pkg::CMD_LOAD: sb_r <= 1'b0;
        qrs_pkg::CMD_RESTART: begin
          peak_count_r <= '0;
          slot_r       <= '0;
          signal_r     <= start_signal_r;
          noise_r      <= start_noise_r;
          upper_r      <= '0;
          lower_r      <= '0;
          rr_low_r     <= start_rr_low_r;
          rr_high_r    <= start_rr_high_r;
          rr_miss_r    <= start_rr_miss_r;
          last_time_r  <= '0;
          misses_r     <= '0;
          all_cnt_r    <= '0;
          good_cnt_r   <= '0;
          all_pos_r    <= '0;
          good_pos_r   <= '0;
          avg_all_r    <= '0;
          avg_good_r   <= '0;
        end
        qrs_pkg::CMD_STORE: begin
          // first peak after restart or count wrap sets the thresholds
          if (peak_count_r == '0) begin
            upper_r <= upper_new;
            lower_r <= upper_new >> 1;
          end
          peak_count_r <= peak_count_r + TW'(1);
          slot_r <= (peak_count_r == TIME_MAX || slot_r == SLOT_LAST) ? '0 : slot_r + SW'(1);
        end
        qrs_pkg::CMD_NOISE: noise_r <= noise_sum[20:3];
        qrs_pkg::CMD_THR: begin
          upper_r <= upper_new;
          lower_r <= upper_new >> 1;
        end
        qrs_pkg::CMD_BEAT: begin
          misses_r    <= '0;
          last_time_r <= item_r.stamp;
          signal_r    <= sigb_sum[20:3];
          all_cnt_r   <= all_cnt_inc;
          all_pos_r   <= all_pos_inc;
          good_cnt_r  <= good_cnt_inc;
          good_pos_r  <= good_pos_inc;
        end
        qrs_pkg::CMD_MISS: misses_r <= miss_hit ? '0 : misses_inc;
        qrs_pkg::CMD_SB_HIT: begin
          last_time_r <= rd_time_r;
          signal_r    <= sigs_sum[19:2];
          all_cnt_r   <= all_cnt_inc;
          all_pos_r   <= all_pos_inc;
          sb_r        <= 1'b1;
        end
        qrs_pkg::CMD_PUT_AVG_ALL:  avg_all_r  <= quot[TW-1:0];
        qrs_pkg::CMD_PUT_AVG_GOOD: avg_good_r <= quot[TW-1:0];
        qrs_pkg::CMD_PUT_LOW:      rr_low_r   <= pct_q_r;
        qrs_pkg::CMD_PUT_HIGH:     rr_high_r  <= pct_q_r;
        qrs_pkg::CMD_PUT_MISS:     rr_miss_r  <= pct_q_r;
        default: ;
      endcase
    end
  end

  // working registers, rings and peak memory
  always_ff @(posedge clk) begin
    unique case (cmd)
      qrs_pkg::CMD_LOAD: begin
        item_r <= in_item;
        res_r  <= '0;
      end
      qrs_pkg::CMD_STORE: begin
        peak_val_mem[slot_r]  <= item_r.s3;
        peak_time_mem[slot_r] <= item_r.stamp;
        cur_r <= slot_r;
        rr_r  <= rr_new;
      end
      qrs_pkg::CMD_BEAT: begin
        all_ring[all_pos_r]   <= rr_r;
        good_ring[good_pos_r] <= rr_r;
        res_r.beat        <= 1'b1;
        res_r.beat_value  <= item_r.s3;
        res_r.beat_time   <= item_r.stamp;
        res_r.rr_interval <= rr_r;
        res_r.weak_beat   <= item_r.s3 < weak_level_r;
        idx_r <= '0;
        acc_r <= '0;
      end
      qrs_pkg::CMD_MISS: res_r.unstable <= miss_hit;
      qrs_pkg::CMD_SB_START: begin
        n_r     <= '0;
        avail_r <= avail_new;
      end
      qrs_pkg::CMD_SB_READ: begin
        rd_val_r  <= peak_val_mem[cur_dec];
        rd_time_r <= peak_time_mem[cur_dec];
        cur_r     <= cur_dec;
      end
      qrs_pkg::CMD_SB_NEXT: n_r <= n_r + SW'(1);
      qrs_pkg::CMD_SB_HIT: begin
        all_ring[all_pos_r] <= srr;
        rr_r <= srr;
        res_r.beat          <= 1'b1;
        res_r.by_searchback <= 1'b1;
        res_r.beat_value    <= rd_val_r;
        res_r.beat_time     <= rd_time_r;
        res_r.rr_interval   <= srr;
        res_r.weak_beat     <= rd_val_r < weak_level_r;
        idx_r <= '0;
        acc_r <= '0;
      end
      qrs_pkg::CMD_SUM_ALL: begin
        acc_r <= acc_r + SUMW'(all_ring[idx_r]);
        idx_r <= idx_r + IW'(1);
      end
      qrs_pkg::CMD_SUM_GOOD: begin
        acc_r <= acc_r + SUMW'(good_ring[idx_r]);
        idx_r <= idx_r + IW'(1);
      end
      qrs_pkg::CMD_DIV_AVG_ALL: begin
        idx_r <= '0;
        acc_r <= '0;
      end
      qrs_pkg::CMD_PUT_RATE:
        res_r.pulse_rate <= (rr_r == '0) ? '0 : quot[qrs_pkg::RATE_W-1:0];
      qrs_pkg::CMD_EMIT: out_r <= res_r;
      default: ;
    endcase
  end

  always_comb begin
    st.op        = item_r.op;
    st.is_peak   = (item_r.s1 < item_r.s2) && (item_r.s2 <= item_r.s3) &&
                   (item_r.s3 >= item_r.s4) && (item_r.s4 > item_r.s5);
    st.above     = item_r.s3 > upper_r;
    st.in_win    = (rr_r > rr_low_r) && (rr_r < rr_high_r);
    st.over_miss = rr_r > rr_miss_r;
    st.sb_end    = n_r == avail_r;
    st.sb_hit    = rd_val_r > lower_r;
    st.all_last  = CW'(idx_r) == all_cnt_r - CW'(1);
    st.good_last = CW'(idx_r) == good_cnt_r - CW'(1);
    st.div_done  = div_done || pct_done_r;
    st.sb        = sb_r;
  end

  assign out_res = out_r;

endmodule

`default_nettype wire

[sv/qrs_ctrl.sv]
// Sequencer of the QRS peak detector: steps the datapath through one item and
// owns the channel handshakes. Depends on qrs_pkg.
`timescale 1ns / 1ps
`default_nettype none

module qrs_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  output logic           out_valid,
  input  logic           out_ready,
  input  qrs_pkg::st_t   st,
  output qrs_pkg::cmd_t  cmd
);

  qrs_pkg::state_t state_r, state_nxt;
  logic            out_valid_r, out_valid_nxt;
  logic            out_free;

  assign out_free = !out_valid_r || out_ready;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      qrs_pkg::S_IDLE:     if (in_valid) state_nxt = qrs_pkg::S_DECODE;
      qrs_pkg::S_DECODE: begin
        priority if (st.op)       state_nxt = qrs_pkg::S_EMIT;
        else if (!st.is_peak)     state_nxt = qrs_pkg::S_EMIT;
        else                      state_nxt = qrs_pkg::S_STORE;
      end
      qrs_pkg::S_STORE:    state_nxt = qrs_pkg::S_CLASSIFY;
      qrs_pkg::S_CLASSIFY: begin
        priority if (!st.above)   state_nxt = qrs_pkg::S_THR;
        else if (st.in_win)       state_nxt = qrs_pkg::S_SUM_ALL;
        else if (st.over_miss)    state_nxt = qrs_pkg::S_SB_START;
        else                      state_nxt = qrs_pkg::S_EMIT;
      end
      qrs_pkg::S_THR:      state_nxt = qrs_pkg::S_EMIT;
      qrs_pkg::S_SB_START: state_nxt = qrs_pkg::S_SB_READ;
      qrs_pkg::S_SB_READ:
        state_nxt = st.sb_end ? qrs_pkg::S_EMIT : qrs_pkg::S_SB_CHECK;
      qrs_pkg::S_SB_CHECK:
        state_nxt = st.sb_hit ? qrs_pkg::S_SUM_ALL : qrs_pkg::S_SB_READ;
      qrs_pkg::S_SUM_ALL:  if (st.all_last) state_nxt = qrs_pkg::S_AVG_ALL_GO;
      qrs_pkg::S_AVG_ALL_GO: state_nxt = qrs_pkg::S_AVG_ALL_WAIT;
      qrs_pkg::S_AVG_ALL_WAIT:
        if (st.div_done) state_nxt = st.sb ? qrs_pkg::S_LOW_GO : qrs_pkg::S_SUM_GOOD;
      qrs_pkg::S_SUM_GOOD: if (st.good_last) state_nxt = qrs_pkg::S_AVG_GOOD_GO;
      qrs_pkg::S_AVG_GOOD_GO: state_nxt = qrs_pkg::S_AVG_GOOD_WAIT;
      qrs_pkg::S_AVG_GOOD_WAIT: if (st.div_done) state_nxt = qrs_pkg::S_LOW_GO;
      qrs_pkg::S_LOW_GO:   state_nxt = qrs_pkg::S_LOW_WAIT;
      qrs_pkg::S_LOW_WAIT: if (st.div_done) state_nxt = qrs_pkg::S_HIGH_GO;
      qrs_pkg::S_HIGH_GO:  state_nxt = qrs_pkg::S_HIGH_WAIT;
      qrs_pkg::S_HIGH_WAIT: if (st.div_done) state_nxt = qrs_pkg::S_MISS_GO;
      qrs_pkg::S_MISS_GO:  state_nxt = qrs_pkg::S_MISS_WAIT;
      qrs_pkg::S_MISS_WAIT: if (st.div_done) state_nxt = qrs_pkg::S_RATE_GO;
      qrs_pkg::S_RATE_GO:  state_nxt = qrs_pkg::S_RATE_WAIT;
      qrs_pkg::S_RATE_WAIT: if (st.div_done) state_nxt = qrs_pkg::S_THR;
      qrs_pkg::S_EMIT:     if (out_free) state_nxt = qrs_pkg::S_IDLE;
      default:             state_nxt = qrs_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd      = qrs_pkg::CMD_NONE;
    in_ready = 1'b0;
    unique case (state_r)
      qrs_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) cmd = qrs_pkg::CMD_LOAD;
      end
      qrs_pkg::S_DECODE:   if (st.op) cmd = qrs_pkg::CMD_RESTART;
      qrs_pkg::S_STORE:    cmd = qrs_pkg::CMD_STORE;
      qrs_pkg::S_CLASSIFY: begin
        priority if (!st.above) cmd = qrs_pkg::CMD_NOISE;
        else if (st.in_win)     cmd = qrs_pkg::CMD_BEAT;
        else                    cmd = qrs_pkg::CMD_MISS;
      end
      qrs_pkg::S_THR:      cmd = qrs_pkg::CMD_THR;
      qrs_pkg::S_SB_START: cmd = qrs_pkg::CMD_SB_START;
      qrs_pkg::S_SB_READ:  if (!st.sb_end) cmd = qrs_pkg::CMD_SB_READ;
      qrs_pkg::S_SB_CHECK:
        cmd = st.sb_hit ? qrs_pkg::CMD_SB_HIT : qrs_pkg::CMD_SB_NEXT;
      qrs_pkg::S_SUM_ALL:       cmd = qrs_pkg::CMD_SUM_ALL;
      qrs_pkg::S_AVG_ALL_GO:    cmd = qrs_pkg::CMD_DIV_AVG_ALL;
      qrs_pkg::S_AVG_ALL_WAIT:  if (st.div_done) cmd = qrs_pkg::CMD_PUT_AVG_ALL;
      qrs_pkg::S_SUM_GOOD:      cmd = qrs_pkg::CMD_SUM_GOOD;
      qrs_pkg::S_AVG_GOOD_GO:   cmd = qrs_pkg::CMD_DIV_AVG_GOOD;
      qrs_pkg::S_AVG_GOOD_WAIT: if (st.div_done) cmd = qrs_pkg::CMD_PUT_AVG_GOOD;
      qrs_pkg::S_LOW_GO:        cmd = qrs_pkg::CMD_DIV_LOW;
      qrs_pkg::S_LOW_WAIT:      if (st.div_done) cmd = qrs_pkg::CMD_PUT_LOW;
      qrs_pkg::S_HIGH_GO:       cmd = qrs_pkg::CMD_DIV_HIGH;
      qrs_pkg::S_HIGH_WAIT:     if (st.div_done) cmd = qrs_pkg::CMD_PUT_HIGH;
      qrs_pkg::S_MISS_GO:       cmd = qrs_pkg::CMD_DIV_MISS;
      qrs_pkg::S_MISS_WAIT:     if (st.div_done) cmd = qrs_pkg::CMD_PUT_MISS;
      qrs_pkg::S_RATE_GO:       cmd = qrs_pkg::CMD_DIV_RATE;
      qrs_pkg::S_RATE_WAIT:     if (st.div_done) cmd = qrs_pkg::CMD_PUT_RATE;
      qrs_pkg::S_EMIT:          if (out_free) cmd = qrs_pkg::CMD_EMIT;
      default: ;
    endcase
  end

  // output register: load on emit, drop once the sink takes the item
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (state_r == qrs_pkg::S_EMIT && out_free) out_valid_nxt = 1'b1;
    else if (out_ready)                         out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= qrs_pkg::S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

`default_nettype wire

[tb/qrs_peak_detector_tb.sv]
// Self-checking bench for the QRS peak detector: random and directed sample windows
// are predicted here and every beat result is checked in order. Needs qrs_pkg and
// the channel interfaces qrs_in_if and qrs_out_if.
`timescale 1ns / 1ps

module qrs_peak_detector_tb;
  import qrs_pkg::*;

  localparam int DEPTH = 64;
  localparam int RRW   = 8;
  localparam logic [23:0] MAX24 = 24'hFFFFFF;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  qrs_in_if  in_ch();
  qrs_out_if out_ch();

  qrs_peak_detector u_dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  // configuration copy
  logic [17:0] weak_lvl;
  logic [2:0]  miss_lim;
  logic [17:0] st_sig, st_noise;
  logic [23:0] st_low, st_high, st_miss;

  // detector state copy
  logic [17:0] pk_val [DEPTH];
  logic [23:0] pk_time [DEPTH];
  logic [23:0] pk_cnt;
  logic [17:0] sig_lvl, noise_lvl, thr_hi, thr_lo;
  logic [23:0] lim_low, lim_high, lim_miss, last_time;
  logic [2:0]  miss_cnt;
  logic [23:0] rr_all [RRW], rr_good [RRW];
  int          n_all, n_good, pos_all, pos_good;
  logic [23:0] avg_all, avg_good;

  res_t beat_q[$];
  int   errors = 0;
  bit   rx_hold = 0;
  bit   idle_on = 1;
  int   timestamp_now = 0;

  function automatic logic [23:0] pct_of(logic [23:0] a, int p);
    longint v;
    v = longint'(a) * p / 100;
    return v > MAX24 ? MAX24 : v[23:0];
  endfunction

  function automatic void restart_state();
    for (int i = 0; i < DEPTH; i++) begin pk_val[i] = 0; pk_time[i] = 0; end
    for (int i = 0; i < RRW; i++) begin rr_all[i] = 0; rr_good[i] = 0; end
    pk_cnt = 0; sig_lvl = st_sig; noise_lvl = st_noise; thr_hi = 0; thr_lo = 0;
    lim_low = st_low; lim_high = st_high; lim_miss = st_miss;
    last_time = 0; miss_cnt = 0;
    n_all = 0; n_good = 0; pos_all = 0; pos_good = 0; avg_all = 0; avg_good = 0;
  endfunction

  function automatic void update_thresholds();
    thr_hi = 18'((3 * longint'(noise_lvl) + sig_lvl) / 4);
    thr_lo = thr_hi / 2;
  endfunction

  function automatic void update_limits(logic [23:0] a);
    lim_low = pct_of(a, 92); lim_high = pct_of(a, 116); lim_miss = pct_of(a, 166);
  endfunction

  function automatic res_t beat_result(logic [17:0] v, logic [23:0] t, logic [23:0] rr,
                                       bit sb, res_t r);
    r.beat = 1; r.by_searchback = sb; r.beat_value = v; r.beat_time = t;
    r.rr_interval = rr; r.pulse_rate = rr == 0 ? 0 : 14'(15000 / rr);
    r.weak_beat = v < weak_lvl;
    return r;
  endfunction

  function automatic res_t predict_beat(in_t it);
    res_t r;
    longint sum;
    int slot, avail, cur;
    logic [23:0] rr, srr;
    r = '0;
    if (it.op) begin restart_state(); return r; end
    if (!(it.s1 < it.s2 && it.s2 <= it.s3 && it.s3 >= it.s4 && it.s4 > it.s5)) return r;
    slot = pk_cnt % DEPTH;
    pk_val[slot] = it.s3; pk_time[slot] = it.stamp;
    if (pk_cnt == 0) update_thresholds();
    pk_cnt = pk_cnt + 1;
    rr = it.stamp - last_time;
    if (it.s3 <= thr_hi) begin
      noise_lvl = 18'((7 * longint'(noise_lvl) + it.s3) / 8);
      update_thresholds();
      return r;
    end
    if (rr > lim_low && rr < lim_high) begin
      miss_cnt = 0;
      rr_all[pos_all] = rr; pos_all = (pos_all + 1) % RRW; if (n_all < RRW) n_all++;
      sum = 0; for (int i = 0; i < n_all; i++) sum += rr_all[i];
      avg_all = 24'(sum / n_all);
      rr_good[pos_good] = rr; pos_good = (pos_good + 1) % RRW; if (n_good < RRW) n_good++;
      sum = 0; for (int i = 0; i < n_good; i++) sum += rr_good[i];
      avg_good = 24'(sum / n_good);
      last_time = it.stamp;
      sig_lvl = 18'((longint'(it.s3) + 7 * longint'(sig_lvl)) / 8);
      update_thresholds();
      update_limits(avg_good);
      return beat_result(it.s3, it.stamp, rr, 0, r);
    end
    miss_cnt = miss_cnt + 1;
    if (miss_cnt >= miss_lim) begin r.unstable = 1; miss_cnt = 0; end
    if (rr > lim_miss) begin
      avail = pk_cnt == 0 ? DEPTH - 1 : (pk_cnt - 1 > DEPTH - 1 ? DEPTH - 1 : pk_cnt - 1);
      cur = slot;
      for (int n = 0; n < avail; n++) begin
        cur = (cur + DEPTH - 1) % DEPTH;
        if (pk_val[cur] > thr_lo) begin
          srr = pk_time[cur] - last_time;
          last_time = pk_time[cur];
          rr_all[pos_all] = srr; pos_all = (pos_all + 1) % RRW; if (n_all < RRW) n_all++;
          sum = 0; for (int i = 0; i < n_all; i++) sum += rr_all[i];
          avg_all = 24'(sum / n_all);
          sig_lvl = 18'((longint'(pk_val[cur]) + 3 * longint'(sig_lvl)) / 4);
          update_limits(avg_all);
          update_thresholds();
          return beat_result(pk_val[cur], pk_time[cur], srr, 1, r);
        end
      end
    end
    return r;
  endfunction

  task automatic idle_burst();
    repeat ($urandom_range(1, 17)) @(posedge clk);
  endtask

  task automatic send_window(in_t it);
    if (idle_on && $urandom_range(0, 5) == 0) begin
      in_ch.valid <= 0;
      idle_burst();
    end
    in_ch.valid <= 1; in_ch.op <= it.op; in_ch.s1 <= it.s1; in_ch.s2 <= it.s2;
    in_ch.s3 <= it.s3; in_ch.s4 <= it.s4; in_ch.s5 <= it.s5; in_ch.stamp <= it.stamp;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    beat_q.push_back(predict_beat(it));
  endtask

  task automatic drain();
    in_ch.valid <= 0;
    while (beat_q.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
  endtask

  task automatic write_reg(cfg_idx_t idx, logic [23:0] val);
    cfg_we <= 1; cfg_index <= idx; cfg_data <= val;
    @(posedge clk);
    cfg_we <= 0;
    case (idx)
      CFG_WEAK_LEVEL:    weak_lvl = val[17:0];
      CFG_MISS_LIMIT:    miss_lim = val[2:0];
      CFG_START_SIGNAL:  st_sig = val[17:0];
      CFG_START_NOISE:   st_noise = val[17:0];
      CFG_START_RR_LOW:  st_low = val;
      CFG_START_RR_HIGH: st_high = val;
      default:           st_miss = val;
    endcase
  endtask

  function automatic in_t peak_window(logic [17:0] h, logic [23:0] t);
    in_t it;
    logic [17:0] p;
    p = h < 4 ? 4 : h;
    it.op = 0; it.s3 = p; it.s2 = p - $urandom_range(0, 1); it.s1 = it.s2 - 1;
    it.s4 = p - $urandom_range(0, 1); it.s5 = it.s4 - 1 - $urandom_range(0, 1);
    it.stamp = t;
    return it;
  endfunction

  function automatic in_t any_window();
    in_t it;
    it = {$urandom, $urandom, $urandom, $urandom};
    it.op = ($urandom_range(0, 40) == 0);
    return it;
  endfunction

  // results checker
  always @(posedge clk) begin
    res_t got, want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got = {out_ch.beat, out_ch.by_searchback, out_ch.beat_value, out_ch.beat_time,
             out_ch.rr_interval, out_ch.pulse_rate, out_ch.weak_beat, out_ch.unstable};
      if (beat_q.size() == 0) begin
        $display("%0t: unexpected item, expected none, actual %h", $time, got);
        errors++;
      end else begin
        want = beat_q.pop_front();
        if (got !== want) begin
          $display("%0t: beat mismatch, expected %p, actual %p", $time, want, got);
          errors++;
        end
      end
    end
  end

  // result side back-pressure; ready drops for a requested hold and in random idle bursts
  initial begin
    out_ch.ready = 1'b0;
    @(posedge clk);
    forever begin
      if (rx_hold) begin
        out_ch.ready <= 0;
        repeat (400) @(posedge clk);
        rx_hold = 0;
      end else if (idle_on && $urandom_range(0, 6) == 0) begin
        out_ch.ready <= 0;
        idle_burst();
        out_ch.ready <= 1;
      end else out_ch.ready <= 1;
      @(posedge clk);
    end
  end

  task automatic test_directed();
    in_t it;
    send_window('{op: 1, default: 0});
    send_window('{op: 0, s1: 0, s2: 1, s3: 18'h3FFFF, s4: 1, s5: 0, stamp: 100});
    send_window('{op: 0, s1: 0, s2: 2, s3: 2, s4: 2, s5: 0, stamp: 200});
    send_window('{op: 0, s1: 5, s2: 5, s3: 9, s4: 1, s5: 0, stamp: 300});
    send_window('{op: 0, s1: 18'h3FFFD, s2: 18'h3FFFE, s3: 18'h3FFFF, s4: 18'h3FFFE,
                  s5: 18'h3FFFD, stamp: MAX24});
    for (int i = 0; i < 12; i++) send_window(peak_window(5000 + 100 * i, 300 * i + 400));
    send_window(peak_window(10, 4000));
    send_window(peak_window(9000, 30000));
    send_window(peak_window(9000, 30001));
    send_window('{op: 1, default: 0});
    drain();
  endtask

  task automatic test_config_sweep();
    write_reg(CFG_WEAK_LEVEL, 18'h3FFFF); write_reg(CFG_MISS_LIMIT, 0);
    write_reg(CFG_START_SIGNAL, 18'h3FFFF); write_reg(CFG_START_NOISE, 0);
    write_reg(CFG_START_RR_LOW, 0); write_reg(CFG_START_RR_HIGH, MAX24);
    write_reg(CFG_START_RR_MISS, 0);
    send_window('{op: 1, default: 0});
    for (int i = 0; i < 80; i++)
      send_window($urandom_range(0, 3) == 0 ? any_window()
                  : peak_window($urandom, $urandom_range(0, MAX24)));
    drain();
    write_reg(CFG_WEAK_LEVEL, 0); write_reg(CFG_MISS_LIMIT, 7);
    write_reg(CFG_START_SIGNAL, 0); write_reg(CFG_START_NOISE, 18'h3FFFF);
    write_reg(CFG_START_RR_LOW, MAX24); write_reg(CFG_START_RR_HIGH, 0);
    write_reg(CFG_START_RR_MISS, MAX24);
    send_window('{op: 1, default: 0});
    for (int i = 0; i < 40; i++) send_window(peak_window($urandom, $urandom));
    drain();
  endtask

  // plausible rhythms with jitter, amplitude variation, noise and dropouts
  task automatic test_rhythm(int items, bit stall);
    int t, rr;
    in_t it;
    write_reg(CFG_WEAK_LEVEL, $urandom_range(0, 60000));
    write_reg(CFG_MISS_LIMIT, $urandom_range(1, 7));
    write_reg(CFG_START_SIGNAL, $urandom_range(0, 40000));
    write_reg(CFG_START_NOISE, $urandom_range(0, 8000));
    write_reg(CFG_START_RR_LOW, $urandom_range(0, 50));
    write_reg(CFG_START_RR_HIGH, $urandom_range(200, 4000));
    write_reg(CFG_START_RR_MISS, $urandom_range(100, 6000));
    send_window('{op: 1, default: 0});
    t = $urandom_range(0, 1000); rr = $urandom_range(60, 400);
    for (int i = 0; i < items; i++) begin
      if (stall && i == 10) rx_hold = 1;
      case ($urandom_range(0, 9))
        0: it = any_window();
        1, 2: begin
          t += $urandom_range(5, rr);
          it = peak_window($urandom_range(0, 6000), t);
        end
        default: begin
          t += rr + $urandom_range(0, 40) - 20 + ($urandom_range(0, 12) == 0 ? 3 * rr : 0);
          it = peak_window($urandom_range(20000, 90000), t);
        end
      endcase
      send_window(it);
    end
    drain();
  endtask

  initial begin
    in_ch.valid = 0; in_ch.op = 0; in_ch.s1 = 0; in_ch.s2 = 0; in_ch.s3 = 0;
    in_ch.s4 = 0; in_ch.s5 = 0; in_ch.stamp = 0;
    weak_lvl = WEAK_LEVEL_RST; miss_lim = MISS_LIMIT_RST; st_sig = START_SIGNAL_RST;
    st_noise = START_NOISE_RST; st_low = START_RR_LOW_RST; st_high = START_RR_HIGH_RST;
    st_miss = START_RR_MISS_RST;
    restart_state();
    repeat (9) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    test_directed();
    test_config_sweep();
    test_rhythm(500, 1);
    for (int k = 0; k < 3; k++) test_rhythm(300, 0);
    idle_on = 0;
    test_rhythm(200, 0);
    if (errors == 0) $display("PASS qrs_peak_detector");
    else $display("FAIL qrs_peak_detector");
    $finish;
  end

  initial begin
    #20ms;
    $display("FAIL qrs_peak_detector");
    $finish;
  end
endmodule
